>>> rtl/gpt_pkg.sv
// Shared types, register codes and helpers for the gamepad poll transceiver.
package gpt_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_START_CMD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_REQUEST_CMD = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ANALOG_ID = 2'd2;

  localparam logic [7:0] START_CMD_RST = 8'h01;
  localparam logic [7:0] REQUEST_CMD_RST = 8'h42;
  localparam logic [7:0] ANALOG_ID_RST = 8'h73;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_SLOT = 1'b1;

  typedef struct packed {
    logic [7:0] start_command;
    logic [7:0] request_command;
    logic [7:0] analog_id;
  } cfg_t;

  typedef struct packed {
    logic        chip_select;
    logic        data_out;
    logic        done_res;
    logic [15:0] buttons;
    logic [4:0]  key_code;
    logic        red_mode;
    logic [7:0]  device_id;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
  } res_t;

  function automatic logic [4:0] key_of(input logic [15:0] btn);
    logic [4:0] key;
    key = 5'd0;
    for (int j = 15; j >= 0; j--) begin
      if (!btn[j]) begin
        key = 5'(j + 1);
      end
    end
    return key;
  endfunction

endpackage

>>> rtl/gpt_cfg_regs.sv
// Configuration registers written through the plain write port.
module gpt_cfg_regs import gpt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_command <= START_CMD_RST;
      cfg_q.request_command <= REQUEST_CMD_RST;
      cfg_q.analog_id <= ANALOG_ID_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_CMD:   cfg_q.start_command <= cfg_wdata_i;
        REG_REQUEST_CMD: cfg_q.request_command <= cfg_wdata_i;
        REG_ANALOG_ID:   cfg_q.analog_id <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/gpt_frame.sv
// Frame state, bit-slot receive store and per-beat result logic.
module gpt_frame import gpt_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic cmd_i,
  input  logic din_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam int unsigned FrameBits = FRAME_BYTES * 8;
  localparam int unsigned StoreDepth = FRAME_BYTES - 2;
  localparam int unsigned PosW = $clog2(FrameBits);
  localparam int unsigned ByteW = PosW - 3;

  logic [PosW-1:0]  pos_q;
  logic             busy_q;
  logic [7:0]       id_q;
  logic [7:0]       store_q [StoreDepth];

  logic [PosW-1:0]  pos_nxt;
  logic [ByteW-1:0] byte_idx;
  logic [2:0]       bit_idx;
  logic             last;
  logic             line_nxt;
  logic [7:0]       rx_view [StoreDepth];
  logic [7:0]       stick [4];
  logic [15:0]      btn;

  assign pos_nxt = pos_q + PosW'(1);
  assign byte_idx = pos_q[PosW-1:3];
  assign bit_idx = pos_q[2:0];
  assign last = (pos_q == PosW'(FrameBits - 1));

  // merge the final bit of the frame into the reported bytes
  always_comb begin
    for (int e = 0; e < StoreDepth; e++) begin
      rx_view[e] = store_q[e];
    end
    rx_view[StoreDepth-1][7] = store_q[StoreDepth-1][7] | (last & din_i);
  end

  assign btn = {rx_view[2], rx_view[1]};

  always_comb begin
    if (pos_nxt < PosW'(8)) begin
      line_nxt = cfg_i.start_command[pos_nxt[2:0]];
    end else if (pos_nxt < PosW'(16)) begin
      line_nxt = cfg_i.request_command[pos_nxt[2:0]];
    end else begin
      line_nxt = cfg_i.request_command[7];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_stick
    if (k + 5 < FRAME_BYTES) begin : g_have
      assign stick[k] = rx_view[k+3];
    end else begin : g_none
      assign stick[k] = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      busy_q <= 1'b0;
      id_q <= 8'd0;
      for (int e = 0; e < StoreDepth; e++) begin
        store_q[e] <= 8'd0;
      end
    end else if (step_i) begin
      if (cmd_i == CMD_START) begin
        pos_q <= '0;
        busy_q <= 1'b1;
        id_q <= 8'd0;
        for (int e = 0; e < StoreDepth; e++) begin
          store_q[e] <= 8'd0;
        end
      end else if (busy_q) begin
        if (din_i && byte_idx == ByteW'(1)) begin
          id_q[bit_idx] <= 1'b1;
        end
        for (int e = 0; e < StoreDepth; e++) begin
          if (din_i && byte_idx == ByteW'(e + 2)) begin
            store_q[e][bit_idx] <= 1'b1;
          end
        end
        if (last) begin
          pos_q <= '0;
          busy_q <= 1'b0;
        end else begin
          pos_q <= pos_nxt;
        end
      end
    end
  end

  always_comb begin
    res_o = '0;
    if (cmd_i == CMD_START) begin
      res_o.chip_select = 1'b1;
      res_o.data_out = cfg_i.start_command[0];
    end else if (!busy_q) begin
      res_o.data_out = cfg_i.request_command[7];
    end else if (!last) begin
      res_o.chip_select = 1'b1;
      res_o.data_out = line_nxt;
    end else begin
      res_o.data_out = cfg_i.request_command[7];
      res_o.done_res = 1'b1;
      res_o.buttons = btn;
      res_o.key_code = key_of(btn);
      res_o.red_mode = (id_q == cfg_i.analog_id);
      res_o.device_id = id_q;
      res_o.right_x = stick[0];
      res_o.right_y = stick[1];
      res_o.left_x = stick[2];
      res_o.left_y = stick[3];
    end
  end

endmodule

>>> rtl/gamepad_poll_transceiver.sv
// Gamepad poll transceiver top level: config, frame logic and result register.
// Result: registered, shown in the cycle after its accepted input beat.
// Throughput: one beat per cycle unless the output stalls; the result register
// lets the next beat in while the previous result is taken.
// Reset: idle, no frame busy, receive store and device id zero, registers
// at their defaults; no clearing pass.
module gamepad_poll_transceiver import gpt_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic                din_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                chip_select_o,
  output logic                data_out_o,
  output logic                done_res_o,
  output logic [15:0]         buttons_o,
  output logic [4:0]          key_code_o,
  output logic                red_mode_o,
  output logic [7:0]          device_id_o,
  output logic [7:0]          right_x_o,
  output logic [7:0]          right_y_o,
  output logic [7:0]          left_x_o,
  output logic [7:0]          left_y_o
);

  cfg_t cfg;
  res_t res_d;
  res_t res_q;
  logic out_valid_q;
  logic accept;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;

  gpt_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  gpt_frame #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame (
    .clk_i,
    .rst_ni,
    .step_i (accept),
    .cmd_i,
    .din_i,
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign chip_select_o = res_q.chip_select;
  assign data_out_o = res_q.data_out;
  assign done_res_o = res_q.done_res;
  assign buttons_o = res_q.buttons;
  assign key_code_o = res_q.key_code;
  assign red_mode_o = res_q.red_mode;
  assign device_id_o = res_q.device_id;
  assign right_x_o = res_q.right_x;
  assign right_y_o = res_q.right_y;
  assign left_x_o = res_q.left_x;
  assign left_y_o = res_q.left_y;

endmodule
